// ===== design/pfm_pkg.sv =====
`default_nettype none

package pfm_pkg;

  // fixed field widths
  localparam int WidthW  = 13;
  localparam int PitchW  = 10;
  localparam int OffsW   = 19;
  localparam int PixW    = 12;
  localparam int GrayW   = 8;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 19;

  // datapath widths, lengths in half micrometres
  localparam int OlW    = WidthW + PitchW;   // width * pitch
  localparam int HalfW  = OffsW + 1;         // doubled offsets and pixel positions
  localparam int OlSqW  = 2 * OlW;
  localparam int HalfSqW = 2 * HalfW;
  localparam int SmaxW  = OlSqW + 1;         // sum of squares
  localparam int AccW   = 64;                // 65025 * s and the residual

  localparam logic [HalfW-1:0] StepHalfUm = HalfW'(200);

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_PITCH  = 2'd1,
    CFG_HEIGHT = 2'd2,
    CFG_DEPTH  = 2'd3
  } cfg_idx_e;

  // data handed from cell to cell
  typedef struct packed {
    logic [AccW-1:0]  rem;    // 65025*s minus root^2*smax
    logic [AccW-1:0]  prod;   // root*smax
    logic [SmaxW-1:0] smax;
    logic [GrayW-1:0] root;
    logic             sat;
    logic             zero;
  } cell_t;

endpackage

`default_nettype wire

// ===== design/projector_falloff_mask_gray.sv =====
`default_nettype none
// Throughput: one pixel per cycle; busy is never raised, the datapath is fully pipelined
// through four front stages and eight square-root cells, one result bit per cell.
// The receiver cannot stall; every result shows for exactly one cycle.
// Reset clears the valid pipe and loads the configuration reset values.

module projector_falloff_mask_gray (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [pfm_pkg::PixW-1:0]       pixel_x_i,
  input  wire logic [pfm_pkg::PixW-1:0]       pixel_y_i,
  output logic                                valid_o,
  output logic [pfm_pkg::GrayW-1:0]           gray_level_o,
  output logic                                saturated_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [pfm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [pfm_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int NumCells = pfm_pkg::GrayW;

  // configuration registers
  logic [pfm_pkg::WidthW-1:0] width_q;
  logic [pfm_pkg::PitchW-1:0] pitch_q;
  logic [pfm_pkg::OffsW-1:0]  height_q, depth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= pfm_pkg::WidthW'(1024);
      pitch_q  <= pfm_pkg::PitchW'(100);
      height_q <= '0;
      depth_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (pfm_pkg::cfg_idx_e'(cfg_idx_i))
        pfm_pkg::CFG_WIDTH:  width_q  <= cfg_data_i[pfm_pkg::WidthW-1:0];
        pfm_pkg::CFG_PITCH:  pitch_q  <= cfg_data_i[pfm_pkg::PitchW-1:0];
        pfm_pkg::CFG_HEIGHT: height_q <= cfg_data_i[pfm_pkg::OffsW-1:0];
        pfm_pkg::CFG_DEPTH:  depth_q  <= cfg_data_i[pfm_pkg::OffsW-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // front stages
  logic           chain_vld [NumCells+1];
  pfm_pkg::cell_t chain_dat [NumCells+1];

  pfm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (start && !busy),
    .pixel_x_i (pixel_x_i),
    .pixel_y_i (pixel_y_i),
    .width_i   (width_q),
    .pitch_i   (pitch_q),
    .height_i  (height_q),
    .depth_i   (depth_q),
    .valid_o   (chain_vld[0]),
    .data_o    (chain_dat[0])
  );

  // square-root cells, most significant bit first
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    pfm_root_cell #(
      .BIT (NumCells - 1 - i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_vld[i]),
      .data_i  (chain_dat[i]),
      .valid_o (chain_vld[i+1]),
      .data_o  (chain_dat[i+1])
    );
  end

  // result register with clamping
  logic                      valid_q, sat_q;
  logic [pfm_pkg::GrayW-1:0] gray_q;

  always_ff @(posedge clk_i) begin
    sat_q <= chain_dat[NumCells].sat;
    priority if (chain_dat[NumCells].sat) begin
      gray_q <= '1;
    end else if (chain_dat[NumCells].zero) begin
      gray_q <= '0;
    end else begin
      gray_q <= chain_dat[NumCells].root;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= chain_vld[NumCells];
    end
  end

  assign valid_o      = valid_q;
  assign gray_level_o = gray_q;
  assign saturated_o  = sat_q;

`ifndef SYNTHESIS
  a_lat_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##13 valid_o)
    else $error("accepted transaction produced no result");
  a_lat_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy, 13))
    else $error("result without accepted transaction");
  a_sat_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && saturated_o) |-> (gray_level_o == '1))
    else $error("saturated result not clamped");
`endif

endmodule

`default_nettype wire

// ===== design/pfm_front.sv =====
`default_nettype none

module pfm_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  input  wire logic [pfm_pkg::PixW-1:0]      pixel_x_i,
  input  wire logic [pfm_pkg::PixW-1:0]      pixel_y_i,
  input  wire logic [pfm_pkg::WidthW-1:0]    width_i,
  input  wire logic [pfm_pkg::PitchW-1:0]    pitch_i,
  input  wire logic [pfm_pkg::OffsW-1:0]     height_i,
  input  wire logic [pfm_pkg::OffsW-1:0]     depth_i,
  output logic                               valid_o,
  output pfm_pkg::cell_t                     data_o
);

  localparam int OlW     = pfm_pkg::OlW;
  localparam int HalfW   = pfm_pkg::HalfW;
  localparam int OlSqW   = pfm_pkg::OlSqW;
  localparam int HalfSqW = pfm_pkg::HalfSqW;
  localparam int SmaxW   = pfm_pkg::SmaxW;
  localparam int AccW    = pfm_pkg::AccW;

  logic [3:0] vld_q;

  // stage 1: offsets and distances
  logic [OlW-1:0]   ol2_d, ol2_q, x2, dx_d, dx_q;
  logic [HalfW-1:0] y2, oh2_d, oh2_q, dz2_q, dy_d, dy_q;

  always_comb begin
    ol2_d = OlW'({{pfm_pkg::PitchW{1'b0}}, width_i} * {{pfm_pkg::WidthW{1'b0}}, pitch_i});
    x2    = OlW'(HalfW'({{(HalfW-pfm_pkg::PixW){1'b0}}, pixel_x_i} * pfm_pkg::StepHalfUm));
    y2    = HalfW'({{(HalfW-pfm_pkg::PixW){1'b0}}, pixel_y_i} * pfm_pkg::StepHalfUm);
    oh2_d = {height_i, 1'b0};
    dx_d  = (x2 >= ol2_d) ? (x2 - ol2_d) : (ol2_d - x2);
    dy_d  = (oh2_d >= y2) ? (oh2_d - y2) : (y2 - oh2_d);
  end

  always_ff @(posedge clk_i) begin
    ol2_q <= ol2_d;
    oh2_q <= oh2_d;
    dz2_q <= {depth_i, 1'b0};
    dx_q  <= dx_d;
    dy_q  <= dy_d;
  end

  // stage 2: squares
  logic [OlSqW-1:0]   dxs_q, ols_q;
  logic [HalfSqW-1:0] dys_q, ohs_q, zs_q;

  always_ff @(posedge clk_i) begin
    dxs_q <= dx_q * dx_q;
    ols_q <= ol2_q * ol2_q;
    dys_q <= dy_q * dy_q;
    ohs_q <= oh2_q * oh2_q;
    zs_q  <= dz2_q * dz2_q;
  end

  // stage 3: distance sums
  logic [SmaxW-1:0] s_q, smax_q;

  always_ff @(posedge clk_i) begin
    s_q    <= SmaxW'(dxs_q) + SmaxW'(dys_q) + SmaxW'(zs_q);
    smax_q <= SmaxW'(ols_q) + SmaxW'(ohs_q) + SmaxW'(zs_q);
  end

  // stage 4: scale by 65025 = 2^16 - 2^9 + 1, saturation test
  logic [AccW-1:0] s_ext, tgt, lim;
  logic            sat_d, zero_d;
  pfm_pkg::cell_t  out_q;

  always_comb begin
    s_ext  = AccW'(s_q);
    tgt    = (s_ext << 16) - (s_ext << 9) + s_ext;
    lim    = AccW'(smax_q) << 16;
    zero_d = (smax_q == '0) && (s_q == '0);
    sat_d  = (smax_q == '0) ? (s_q != '0) : (lim <= tgt);
  end

  always_ff @(posedge clk_i) begin
    out_q.rem  <= tgt;
    out_q.prod <= '0;
    out_q.smax <= smax_q;
    out_q.root <= '0;
    out_q.sat  <= sat_d;
    out_q.zero <= zero_d;
  end

  // valid pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  assign valid_o = vld_q[3];
  assign data_o  = out_q;

endmodule

`default_nettype wire

// ===== design/pfm_root_cell.sv =====
`default_nettype none

module pfm_root_cell #(
  parameter int BIT = 0
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  input  pfm_pkg::cell_t data_i,
  output logic       valid_o,
  output pfm_pkg::cell_t data_o
);

  localparam int AccW = pfm_pkg::AccW;

  logic [AccW-1:0] smax_sh, cand, term;
  logic            take;
  pfm_pkg::cell_t  data_d, data_q;
  logic            valid_q;

  // try setting this root bit: (2*root*b + b^2)*smax against the residual
  always_comb begin
    smax_sh = AccW'(data_i.smax) << BIT;
    cand    = (data_i.prod << 1) + smax_sh;
    term    = cand << BIT;
    take    = (term <= data_i.rem);
    data_d  = data_i;
    if (take) begin
      data_d.rem       = data_i.rem - term;
      data_d.prod      = data_i.prod + smax_sh;
      data_d.root[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`default_nettype none

module testbench;

  typedef struct packed {
    logic [pfm_pkg::PixW-1:0] x;
    logic [pfm_pkg::PixW-1:0] y;
  } pixel_t;

  typedef struct packed {
    logic [pfm_pkg::GrayW-1:0] gray;
    logic                      sat;
  } level_t;

  localparam int DrainCycles = 20;
  localparam int CycleLimit  = 200000;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic [pfm_pkg::PixW-1:0]     pixel_x_i = '0;
  logic [pfm_pkg::PixW-1:0]     pixel_y_i = '0;
  logic                         valid_o;
  logic [pfm_pkg::GrayW-1:0]    gray_level_o;
  logic                         saturated_o;
  logic                         cfg_we_i = 1'b0;
  logic [pfm_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [pfm_pkg::CfgDataW-1:0] cfg_data_i = '0;

  // shadow copy of the configuration
  logic [pfm_pkg::WidthW-1:0] screen_width = 13'd1024;
  logic [pfm_pkg::PitchW-1:0] pitch_um     = 10'd100;
  logic [pfm_pkg::OffsW-1:0]  axis_height  = '0;
  logic [pfm_pkg::OffsW-1:0]  depth        = '0;

  pixel_t pending_pixels[$];
  level_t expected_levels[$];
  bit     gap_free = 1'b0;
  int     errors = 0;
  int     pixels_sent = 0;
  int     levels_checked = 0;
  int     clamps_seen = 0;
  int     cycles = 0;

  projector_falloff_mask_gray dut (
    .clk_i, .rst_ni, .start, .busy, .pixel_x_i, .pixel_y_i, .valid_o,
    .gray_level_o, .saturated_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // exact mask level for one pixel, lengths doubled to stay integral
  function automatic level_t mask_level(input pixel_t p);
    longint unsigned half_w, oh, dz, zz, dx, dy, sq_dist, sq_dist_max, q;
    logic [8:0] root;
    level_t r;
    half_w = longint'(screen_width) * longint'(pitch_um);
    oh     = 2 * longint'(axis_height);
    dz     = 2 * longint'(depth);
    zz     = dz * dz;
    dx = 200 * longint'(p.x);
    dx = (dx >= half_w) ? dx - half_w : half_w - dx;
    dy = 200 * longint'(p.y);
    dy = (oh >= dy) ? oh - dy : dy - oh;
    sq_dist     = dx * dx + dy * dy + zz;
    sq_dist_max = half_w * half_w + oh * oh + zz;
    if (sq_dist_max == 0) begin
      r.gray = (sq_dist == 0) ? 8'd0 : 8'd255;
      r.sat  = (sq_dist != 0);
    end else begin
      q = (65025 * sq_dist) / sq_dist_max;
      if (q >= 65536) begin
        r.gray = 8'd255;
        r.sat  = 1'b1;
      end else begin
        root = '0;
        for (int b = 7; b >= 0; b--) begin
          if (longint'(root | (9'd1 << b)) * longint'(root | (9'd1 << b)) <= q)
            root = root | (9'd1 << b);
        end
        r.gray = root[7:0];
        r.sat  = 1'b0;
      end
    end
    return r;
  endfunction

  // sender: next pixel on the falling edge, random gaps
  always @(negedge clk_i) begin
    if (rst_ni && pending_pixels.size() > 0 && (gap_free || $urandom_range(99) >= 37)) begin
      start     <= 1'b1;
      pixel_x_i <= pending_pixels[0].x;
      pixel_y_i <= pending_pixels[0].y;
    end else begin
      start <= 1'b0;
    end
  end

  // accepted transaction: record its expected level
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) begin
      expected_levels.push_back(mask_level(pending_pixels.pop_front()));
      pixels_sent++;
    end
  end

  // result check against the oldest expectation
  always @(posedge clk_i) begin
    level_t e;
    if (rst_ni && valid_o) begin
      if (expected_levels.size() == 0) begin
        $error("unexpected result gray=%0d sat=%0d", gray_level_o, saturated_o);
        errors++;
      end else begin
        e = expected_levels.pop_front();
        levels_checked++;
        if (saturated_o) clamps_seen++;
        if (gray_level_o !== e.gray) begin
          $error("gray_level expected %0d actual %0d", e.gray, gray_level_o);
          errors++;
        end
        if (saturated_o !== e.sat) begin
          $error("saturated expected %0d actual %0d", e.sat, saturated_o);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic drain();
    while (pending_pixels.size() > 0 || expected_levels.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // write all four registers while the pipe is empty
  task automatic load_config(input logic [pfm_pkg::WidthW-1:0] w,
                             input logic [pfm_pkg::PitchW-1:0] p,
                             input logic [pfm_pkg::OffsW-1:0] h,
                             input logic [pfm_pkg::OffsW-1:0] d);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= pfm_pkg::CFG_WIDTH;
    cfg_data_i <= pfm_pkg::CfgDataW'(w);
    @(negedge clk_i);
    cfg_idx_i <= pfm_pkg::CFG_PITCH;  cfg_data_i <= pfm_pkg::CfgDataW'(p);
    @(negedge clk_i);
    cfg_idx_i <= pfm_pkg::CFG_HEIGHT; cfg_data_i <= h;
    @(negedge clk_i);
    cfg_idx_i <= pfm_pkg::CFG_DEPTH;  cfg_data_i <= d;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    screen_width = w; pitch_um = p; axis_height = h; depth = d;
  endtask

  task automatic push_corners();
    pending_pixels.push_back('{12'd0, 12'd0});
    pending_pixels.push_back('{12'd4095, 12'd4095});
    pending_pixels.push_back('{12'd0, 12'd4095});
    pending_pixels.push_back('{12'd4095, 12'd0});
    pending_pixels.push_back('{12'd512, 12'd0});
    pending_pixels.push_back('{12'd2730, 12'd1365});
  endtask

  task automatic push_random(input int n);
    pixel_t p;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: p = '{pfm_pkg::PixW'($urandom_range(1023)), pfm_pkg::PixW'($urandom_range(1023))};
        1: p = '{pfm_pkg::PixW'($urandom_range(4095, 4000)),
                 pfm_pkg::PixW'($urandom_range(95))};
        default: p = '{pfm_pkg::PixW'($urandom), pfm_pkg::PixW'($urandom)};
      endcase
      pending_pixels.push_back(p);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset configuration, corners and clamping
    push_corners();
    push_random(120);
    drain();

    // zero reference distance
    load_config(13'd0, 10'd100, '0, '0);
    pending_pixels.push_back('{12'd0, 12'd0});
    pending_pixels.push_back('{12'd1, 12'd0});
    pending_pixels.push_back('{12'd0, 12'd1});
    push_random(40);
    drain();

    // largest registers
    load_config(13'h1fff, 10'h3ff, 19'h7ffff, 19'h7ffff);
    push_corners();
    push_random(120);
    drain();

    // smallest in-range registers
    load_config(13'd1, 10'd1, '0, '0);
    push_corners();
    push_random(80);
    drain();

    // a typical setup, long run without gaps, a full pause, then a run with random gaps
    load_config(13'd1920, 10'd250, 19'd120000, 19'd300000);
    gap_free = 1'b1;
    push_random(150);
    drain();
    gap_free = 1'b0;
    push_random(100);
    drain();

    // random registers
    for (int k = 0; k < 4; k++) begin
      load_config(pfm_pkg::WidthW'($urandom), pfm_pkg::PitchW'($urandom),
                  pfm_pkg::OffsW'($urandom), pfm_pkg::OffsW'($urandom));
      push_random(85);
      drain();
    end

    $display("covered %0d pixels over 9 register settings, %0d results, %0d clamped",
             pixels_sent, levels_checked, clamps_seen);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== projector_falloff_mask_gray.f =====
design/pfm_pkg.sv
design/pfm_front.sv
design/pfm_root_cell.sv
design/projector_falloff_mask_gray.sv
verif/testbench.sv
